// File: rtl/core/vrt_pkg.sv
// Shared types and constants for the voxel ray traversal block.
// No dependencies; imported by every module of the block but vrt_ram.
package vrt_pkg;

  localparam int FRAC_BITS = 16;  // origin, distance and surface fraction bits
  localparam int DIR_FRAC  = 15;  // direction is Q1.15
  localparam int ORG_W     = 21;
  localparam int DIR_W     = 16;
  localparam int VOX_W     = 5;
  localparam int BLK_W     = 8;
  localparam int CELL_W    = 9;   // holds cell indexes up to 511
  localparam int OCELL_W   = 6;
  localparam int Q_W       = 32;  // per-axis step 2^31 / |dir|
  localparam int REM_W     = 16;
  localparam int LEN_W     = 41;  // boundary distance, grows by one step per cell
  localparam int DIST_W    = 22;
  localparam int SURF_W    = 23;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Y   = 2'd1;
  localparam logic [1:0] AX_Z   = 2'd2;
  localparam logic [1:0] AX_END = 2'd3;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_SKY   = 2'd1,
    OUT_START = 2'd2
  } outcome_t;

  typedef struct packed {
    logic       clr;        // clearing pass write
    logic       wr;         // voxel write request accepted
    logic       load;       // cast request accepted
    logic       div_start;
    logic [1:0] div_axis;
    logic       len_ld;     // take quotient, set step and first boundary
    logic [1:0] axis;
    logic       eval;       // voxel read data is valid
    logic       step;
    logic       fin;
    outcome_t   code;
    logic       dmax;
    logic       smul;
    logic       sadd;
  } vrt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_out;
    logic div_done;
    logic blk_nz;
    logic ax_inf;
    logic exit_nxt;
  } vrt_sts_t;

endpackage

// File: rtl/core/vrt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module vrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/vrt_div.sv
// Restoring divider, one quotient bit per cycle: 2^31 / divisor.
// Depends on vrt_pkg.
module vrt_div import vrt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIR_W-1:0] divisor,
  output logic [Q_W-1:0]   quot,
  output logic             done
);

  localparam int CW = $clog2(Q_W);
  localparam logic [CW-1:0] LAST = CW'(Q_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [Q_W-1:0]   q_r;
  logic [DIR_W-1:0] dvs_r;
  logic [REM_W:0]   trial;
  logic             take;

  // dividend bits shift out of the top of q_r as quotient bits enter below
  assign trial = {rem_r, q_r[Q_W-1]};
  assign take  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= Q_W'(1) << (Q_W - 1);
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? REM_W'(trial - {1'b0, dvs_r}) : trial[REM_W-1:0];
      q_r   <= {q_r[Q_W-2:0], take};
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

// File: rtl/core/vrt_dp.sv
// Datapath: voxel store, ray state, divider, boundary compare, surface point.
// Depends on vrt_pkg, vrt_ram and vrt_div.
module vrt_dp import vrt_pkg::*; #(
  parameter int SIZE_X  = 32,
  parameter int SIZE_Y  = 32,
  parameter int SIZE_Z  = 32,
  parameter int ID_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  vrt_cmd_t                 cmd,
  output vrt_sts_t                 sts,
  input  logic [VOX_W-1:0]         in_voxel_x,
  input  logic [VOX_W-1:0]         in_voxel_y,
  input  logic [VOX_W-1:0]         in_voxel_z,
  input  logic [BLK_W-1:0]         in_voxel_block,
  input  logic [ORG_W-1:0]         in_origin_x,
  input  logic [ORG_W-1:0]         in_origin_y,
  input  logic [ORG_W-1:0]         in_origin_z,
  input  logic signed [DIR_W-1:0]  in_dir_x,
  input  logic signed [DIR_W-1:0]  in_dir_y,
  input  logic signed [DIR_W-1:0]  in_dir_z,
  output logic [1:0]               out_outcome,
  output logic [BLK_W-1:0]         out_hit_block,
  output logic [OCELL_W-1:0]       out_cell_x,
  output logic [OCELL_W-1:0]       out_cell_y,
  output logic [OCELL_W-1:0]       out_cell_z,
  output logic [DIST_W-1:0]        out_distance,
  output logic signed [SURF_W-1:0] out_surface_x,
  output logic signed [SURF_W-1:0] out_surface_y,
  output logic signed [SURF_W-1:0] out_surface_z
);

  localparam int DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = SURF_W + DIR_W;
  localparam int SW    = SURF_W + 2;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] SMAX = SW'((1 << (SURF_W - 1)) - 1);
  localparam logic signed [SW-1:0] SMIN = -SW'(1 << (SURF_W - 1));

  function automatic logic [CELL_W-1:0] axis_size(input logic [1:0] ax);
    case (ax)
      AX_X:    axis_size = CELL_W'(SIZE_X);
      AX_Y:    axis_size = CELL_W'(SIZE_Y);
      default: axis_size = CELL_W'(SIZE_Z);
    endcase
  endfunction

  function automatic logic [DIR_W-1:0] mag(input logic signed [DIR_W-1:0] d);
    mag = (d < 0) ? DIR_W'(-d) : DIR_W'(d);
  endfunction

  logic [ORG_W-1:0]         org_r  [3];
  logic signed [DIR_W-1:0]  dir_r  [3];
  logic [CELL_W-1:0]        cell_r [3];
  logic [Q_W-1:0]           unit_r [3];
  logic [LEN_W-1:0]         len_r  [3];
  logic [LEN_W-1:0]         d_r;
  logic [ID_BITS-1:0]       blk_r;
  logic signed [SURF_W-1:0] t_r;
  logic signed [PW-1:0]     prod_r;
  logic [1:0]               pax_r;
  logic [AW-1:0]            clr_cnt_r;

  outcome_t                 outcome_r;
  logic [BLK_W-1:0]         hblk_r;
  logic [OCELL_W-1:0]       ocell_r [3];
  logic [DIST_W-1:0]        dist_r;
  logic signed [SURF_W-1:0] surf_r  [3];

  logic                     inf [3];
  logic                     lt01, lt02, lt12;
  logic [1:0]               a;
  logic [CELL_W-1:0]        cell_step;
  logic [AW-1:0]            caddr, waddr, ram_addr;
  logic                     wr_ok, ram_we;
  logic [ID_BITS-1:0]       ram_wdata, rdata;
  logic [Q_W-1:0]           quot;
  logic                     div_done;
  logic [Q_W-1:0]           u_v;
  logic [FRAC_BITS:0]       f_v;
  logic [FRAC_BITS-1:0]     frac_v;
  logic [FRAC_BITS+Q_W:0]   lprod;
  logic [DIST_W-1:0]        dsat, dist_v;
  logic signed [SURF_W-1:0] t_v;
  logic signed [SW-1:0]     sh_v, sum_v;
  logic signed [SURF_W-1:0] sat_v;

  // nearest boundary; ties go to x only if strictly smallest, then y below z
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      inf[k] = (dir_r[k] == '0);
    end
    lt01 = !inf[0] && (inf[1] || len_r[0] < len_r[1]);
    lt02 = !inf[0] && (inf[2] || len_r[0] < len_r[2]);
    lt12 = !inf[1] && (inf[2] || len_r[1] < len_r[2]);
    if (lt01 && lt02) begin
      a = AX_X;
    end else if (lt12) begin
      a = AX_Y;
    end else begin
      a = AX_Z;
    end
    cell_step = (dir_r[a] > 0) ? cell_r[a] + 1'b1 : cell_r[a] - 1'b1;
  end

  assign caddr = AW'((cell_r[2] * SIZE_Y + cell_r[1]) * SIZE_X + cell_r[0]);
  assign waddr = AW'((in_voxel_z * SIZE_Y + in_voxel_y) * SIZE_X + in_voxel_x);
  assign wr_ok = (int'(in_voxel_x) < SIZE_X) && (int'(in_voxel_y) < SIZE_Y) &&
                 (int'(in_voxel_z) < SIZE_Z);

  assign ram_we    = cmd.clr || (cmd.wr && wr_ok);
  assign ram_addr  = cmd.clr ? clr_cnt_r : (cmd.wr ? waddr : caddr);
  assign ram_wdata = cmd.clr ? '0 : ID_BITS'(in_voxel_block);

  vrt_ram #(.WIDTH(ID_BITS), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  vrt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (mag(dir_r[cmd.div_axis])),
    .quot    (quot),
    .done    (div_done)
  );

  always_comb begin
    sts.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
    sts.start_out = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (cell_r[k] == '0 || cell_r[k] >= axis_size(2'(k))) begin
        sts.start_out = 1'b1;
      end
    end
    sts.div_done = div_done;
    sts.blk_nz   = (rdata != '0);
    sts.ax_inf   = inf[a];
    sts.exit_nxt = (cell_step == '0) || (cell_step >= axis_size(a));
  end

  // first boundary distance for the axis whose division just finished
  always_comb begin
    u_v    = inf[cmd.axis] ? '0 : quot;
    frac_v = org_r[cmd.axis][FRAC_BITS-1:0];
    f_v    = (dir_r[cmd.axis] > 0) ? ONE - {1'b0, frac_v} : {1'b0, frac_v};
    lprod  = f_v * u_v;
  end

  always_comb begin
    dsat   = (d_r > LEN_W'(DIST_MAX)) ? DIST_MAX : d_r[DIST_W-1:0];
    dist_v = cmd.dmax ? DIST_MAX : dsat;
    t_v    = SURF_W'({1'b0, dist_v}) - SURF_W'(cmd.code == OUT_HIT);
    sh_v   = SW'(prod_r >>> DIR_FRAC);
    sum_v  = $signed({{(SW - ORG_W){1'b0}}, org_r[pax_r]}) + sh_v;
    if (sum_v > SMAX) begin
      sat_v = SMAX[SURF_W-1:0];
    end else if (sum_v < SMIN) begin
      sat_v = SMIN[SURF_W-1:0];
    end else begin
      sat_v = sum_v[SURF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      org_r[0]  <= in_origin_x;
      org_r[1]  <= in_origin_y;
      org_r[2]  <= in_origin_z;
      dir_r[0]  <= in_dir_x;
      dir_r[1]  <= in_dir_y;
      dir_r[2]  <= in_dir_z;
      cell_r[0] <= CELL_W'(in_origin_x >> FRAC_BITS);
      cell_r[1] <= CELL_W'(in_origin_y >> FRAC_BITS);
      cell_r[2] <= CELL_W'(in_origin_z >> FRAC_BITS);
      d_r       <= '0;
    end
    if (cmd.len_ld) begin
      unit_r[cmd.axis] <= u_v;
      len_r[cmd.axis]  <= LEN_W'(lprod >> FRAC_BITS);
    end
    if (cmd.eval) begin
      blk_r <= rdata;
    end
    if (cmd.step) begin
      cell_r[a] <= cell_step;
      d_r       <= len_r[a];
      len_r[a]  <= len_r[a] + LEN_W'(unit_r[a]);
    end
    if (cmd.fin) begin
      outcome_r <= cmd.code;
      hblk_r    <= (cmd.code == OUT_HIT) ? BLK_W'(blk_r) : '0;
      for (int k = 0; k < 3; k++) begin
        ocell_r[k] <= cell_r[k][OCELL_W-1:0];
      end
      dist_r <= dist_v;
      t_r    <= t_v;
    end
    if (cmd.smul) begin
      prod_r <= t_r * dir_r[cmd.axis];
      pax_r  <= cmd.axis;
    end
    if (cmd.sadd) begin
      surf_r[pax_r] <= sat_v;
    end
  end

  assign out_outcome   = outcome_r;
  assign out_hit_block = hblk_r;
  assign out_cell_x    = ocell_r[0];
  assign out_cell_y    = ocell_r[1];
  assign out_cell_z    = ocell_r[2];
  assign out_distance  = dist_r;
  assign out_surface_x = surf_r[0];
  assign out_surface_y = surf_r[1];
  assign out_surface_z = surf_r[2];

endmodule

// File: rtl/core/vrt_ctrl.sv
// Controller: clearing pass, request handshake, cast sequencing, result valid.
// Depends on vrt_pkg.
module vrt_ctrl import vrt_pkg::*; #(
  parameter int SIZE_X = 32,
  parameter int SIZE_Y = 32,
  parameter int SIZE_Z = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output vrt_cmd_t cmd,
  input  vrt_sts_t sts
);

  localparam int LIMIT = SIZE_X + SIZE_Y + SIZE_Z + 4;
  localparam int NW    = $clog2(LIMIT);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHK, S_DIV, S_READ, S_EVAL, S_FIN, S_SURF
  } state_t;

  state_t          state_r;
  logic [1:0]      ax_r;
  logic [NW-1:0]   n_r;
  outcome_t        code_r;
  logic            dmax_r;
  logic            out_valid_r;
  logic            accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd      = '0;
    cmd.code = OUT_HIT;
    cmd.clr  = (state_r == S_CLEAR);
    cmd.wr   = accept && !in_func;
    cmd.load = accept && in_func;
    case (state_r)
      S_CHK: begin
        if (!sts.start_out) begin
          cmd.div_start = 1'b1;
          cmd.div_axis  = AX_X;
        end
      end
      S_DIV: begin
        cmd.axis = ax_r;
        if (sts.div_done) begin
          cmd.len_ld = 1'b1;
          if (ax_r != AX_Z) begin
            cmd.div_start = 1'b1;
            cmd.div_axis  = ax_r + 1'b1;
          end
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        cmd.step = !sts.blk_nz && !sts.ax_inf;
      end
      S_FIN: begin
        cmd.fin  = !out_valid_r;
        cmd.code = code_r;
        cmd.dmax = dmax_r;
      end
      S_SURF: begin
        cmd.axis = ax_r;
        cmd.smul = (ax_r != AX_END);
        cmd.sadd = (ax_r != AX_X);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ax_r        <= AX_X;
      n_r         <= '0;
      code_r      <= OUT_HIT;
      dmax_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (sts.clr_last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && in_func) state_r <= S_CHK;
        end
        S_CHK: begin
          if (sts.start_out) begin
            code_r  <= OUT_START;
            dmax_r  <= 1'b0;
            state_r <= S_FIN;
          end else begin
            ax_r    <= AX_X;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            if (ax_r == AX_Z) begin
              n_r     <= '0;
              state_r <= S_READ;
            end else begin
              ax_r <= ax_r + 1'b1;
            end
          end
        end
        S_READ: state_r <= S_EVAL;
        S_EVAL: begin
          if (sts.blk_nz) begin
            code_r  <= OUT_HIT;
            dmax_r  <= 1'b0;
            state_r <= S_FIN;
          end else if (sts.ax_inf) begin
            // no finite boundary left on the chosen axis
            code_r  <= OUT_SKY;
            dmax_r  <= 1'b1;
            state_r <= S_FIN;
          end else if (sts.exit_nxt || n_r == NW'(LIMIT - 1)) begin
            code_r  <= OUT_SKY;
            dmax_r  <= 1'b0;
            state_r <= S_FIN;
          end else begin
            n_r     <= n_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_FIN: begin
          if (!out_valid_r) begin
            ax_r    <= AX_X;
            state_r <= S_SURF;
          end
        end
        S_SURF: begin
          if (ax_r == AX_END) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            ax_r <= ax_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/voxel_ray_traversal_3d.sv
// Top level of the voxel ray traversal block: controller plus datapath.
// Depends on vrt_pkg, vrt_ctrl and vrt_dp.
//
// A write request stores one block id. A cast request walks the grid with
// 3D DDA and returns one result. A ray that leaves the grid after N steps
// reads N cells. A ray that stops on a block, or has no direction, reads
// N + 1. A cast's time is set by three serial reciprocal divisions, one
// quotient bit a cycle, and by the registered voxel read of each cell, which
// passes through the S_READ and S_EVAL states. A start outside the grid skips
// the divisions and the walk. After reset the voxel store is cleared to air
// one entry a cycle, all SIZE_X*SIZE_Y*SIZE_Z entries (32768 by default),
// with in_ready low. A finished result waits in the output register while the
// next request is taken; a cast only stalls at its end if that register is
// still full.
module voxel_ray_traversal_3d import vrt_pkg::*; #(
  parameter int SIZE_X  = 32,
  parameter int SIZE_Y  = 32,
  parameter int SIZE_Z  = 32,
  parameter int ID_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic [VOX_W-1:0]         in_voxel_x,
  input  logic [VOX_W-1:0]         in_voxel_y,
  input  logic [VOX_W-1:0]         in_voxel_z,
  input  logic [BLK_W-1:0]         in_voxel_block,
  input  logic [ORG_W-1:0]         in_origin_x,
  input  logic [ORG_W-1:0]         in_origin_y,
  input  logic [ORG_W-1:0]         in_origin_z,
  input  logic signed [DIR_W-1:0]  in_dir_x,
  input  logic signed [DIR_W-1:0]  in_dir_y,
  input  logic signed [DIR_W-1:0]  in_dir_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_outcome,
  output logic [BLK_W-1:0]         out_hit_block,
  output logic [OCELL_W-1:0]       out_cell_x,
  output logic [OCELL_W-1:0]       out_cell_y,
  output logic [OCELL_W-1:0]       out_cell_z,
  output logic [DIST_W-1:0]        out_distance,
  output logic signed [SURF_W-1:0] out_surface_x,
  output logic signed [SURF_W-1:0] out_surface_y,
  output logic signed [SURF_W-1:0] out_surface_z
);

  vrt_cmd_t cmd;
  vrt_sts_t sts;

  vrt_ctrl #(.SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vrt_dp #(
    .SIZE_X(SIZE_X), .SIZE_Y(SIZE_Y), .SIZE_Z(SIZE_Z), .ID_BITS(ID_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_voxel_x     (in_voxel_x),
    .in_voxel_y     (in_voxel_y),
    .in_voxel_z     (in_voxel_z),
    .in_voxel_block (in_voxel_block),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .in_origin_z    (in_origin_z),
    .in_dir_x       (in_dir_x),
    .in_dir_y       (in_dir_y),
    .in_dir_z       (in_dir_z),
    .out_outcome    (out_outcome),
    .out_hit_block  (out_hit_block),
    .out_cell_x     (out_cell_x),
    .out_cell_y     (out_cell_y),
    .out_cell_z     (out_cell_z),
    .out_distance   (out_distance),
    .out_surface_x  (out_surface_x),
    .out_surface_y  (out_surface_y),
    .out_surface_z  (out_surface_z)
  );

endmodule

// File: rtl/core/vrt_checker.sv
// Port-level checks for the voxel ray traversal block, bound to the top level.
// Depends on vrt_pkg and voxel_ray_traversal_3d.
module vrt_checker import vrt_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               out_outcome,
  input logic [BLK_W-1:0]         out_hit_block,
  input logic [DIST_W-1:0]        out_distance,
  input logic signed [SURF_W-1:0] out_surface_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) &&
      $stable(out_outcome) && $stable(out_surface_x))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == OUT_HIT) || (out_outcome == OUT_SKY) ||
      (out_outcome == OUT_START))
    else $error("undefined outcome code");

  a_start_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OUT_START |-> out_distance == '0 &&
      out_hit_block == '0)
    else $error("outside start with nonzero distance or block");

  a_sky_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OUT_SKY |-> out_hit_block == '0)
    else $error("sky result carries a block id");

endmodule

bind voxel_ray_traversal_3d vrt_checker u_vrt_checker (.*);

// File: bench/tb_voxel_ray_traversal_3d.sv
// Testbench for voxel_ray_traversal_3d: random and directed write and cast requests
// drive the block, and cast results are checked against a behavioral DDA walker kept
// in this file. Depends on vrt_pkg and the RTL of the block.
module tb_voxel_ray_traversal_3d;
  import vrt_pkg::*;

  typedef struct {
    logic [1:0]        outcome;
    logic [BLK_W-1:0]  hit_block;
    logic [OCELL_W-1:0] cell_x, cell_y, cell_z;
    logic [DIST_W-1:0] distance;
    logic [SURF_W-1:0] surface_x, surface_y, surface_z;
  } ray_result_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic in_func = 0;
  logic [VOX_W-1:0] in_voxel_x = '0, in_voxel_y = '0, in_voxel_z = '0;
  logic [BLK_W-1:0] in_voxel_block = '0;
  logic [ORG_W-1:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [DIR_W-1:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_outcome;
  logic [BLK_W-1:0] out_hit_block;
  logic [OCELL_W-1:0] out_cell_x, out_cell_y, out_cell_z;
  logic [DIST_W-1:0] out_distance;
  logic signed [SURF_W-1:0] out_surface_x, out_surface_y, out_surface_z;

  voxel_ray_traversal_3d u_dut (.*);

  localparam int GRID = 32;

  logic [BLK_W-1:0] grid_model [GRID*GRID*GRID];
  ray_result_t pending_hits [$];
  int  errors = 0;
  int  hold_cnt = 0;
  int  stall_cnt = 0;
  bit  no_gaps = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic longint floor_q15(longint p);
    if (p >= 0) return p >>> 15;
    return -(((-p) + 32767) >>> 15);
  endfunction

  function automatic ray_result_t pack_ray(logic [1:0] oc, longint blk, longint cix[3],
                                           longint dist_in, bit pull, longint org[3],
                                           longint dir[3]);
    ray_result_t r;
    longint dd, t, s[3];
    dd = (dist_in > longint'(DIST_MAX)) ? longint'(DIST_MAX) : dist_in;
    t = dd - (pull ? 1 : 0);
    for (int k = 0; k < 3; k++) begin
      s[k] = org[k] + floor_q15(t * dir[k]);
      if (s[k] > 64'sh3FFFFF) s[k] = 64'sh3FFFFF;
      if (s[k] < -64'sh400000) s[k] = -64'sh400000;
    end
    r.outcome = oc;
    r.hit_block = blk[7:0];
    r.cell_x = cix[0][5:0]; r.cell_y = cix[1][5:0]; r.cell_z = cix[2][5:0];
    r.distance = dd[21:0];
    r.surface_x = s[0][22:0]; r.surface_y = s[1][22:0]; r.surface_z = s[2][22:0];
    return r;
  endfunction

  // DDA walk over the shadow grid
  function automatic ray_result_t trace_ray(logic [20:0] ox, oy, oz,
                                            logic signed [15:0] dx, dy, dz);
    longint org[3], dir[3], cix[3], unit[3], len[3], frac, mag, d;
    bit inf[3], lt01, lt02, lt12;
    logic [7:0] blk;
    int a;
    org = '{ox, oy, oz};
    dir = '{dx, dy, dz};
    d = 0;
    for (int k = 0; k < 3; k++) begin
      cix[k] = org[k] >> FRAC_BITS;
      frac = org[k] & 64'hFFFF;
      inf[k] = (dir[k] == 0);
      mag = dir[k] < 0 ? -dir[k] : dir[k];
      unit[k] = inf[k] ? 0 : (64'sd1 << 31) / mag;
      len[k] = (((dir[k] > 0) ? 65536 - frac : frac) * unit[k]) >> FRAC_BITS;
    end
    for (int k = 0; k < 3; k++)
      if (cix[k] == 0 || cix[k] >= GRID)
        return pack_ray(OUT_START, 0, cix, 0, 1'b0, org, dir);
    for (int n = 0; n < 3*GRID + 4; n++) begin
      blk = grid_model[(cix[2]*GRID + cix[1])*GRID + cix[0]];
      if (blk != 0) return pack_ray(OUT_HIT, blk, cix, d, 1'b1, org, dir);
      lt01 = !inf[0] && (inf[1] || len[0] < len[1]);
      lt02 = !inf[0] && (inf[2] || len[0] < len[2]);
      lt12 = !inf[1] && (inf[2] || len[1] < len[2]);
      if (lt01 && lt02) a = 0;
      else if (lt12) a = 1;
      else a = 2;
      if (inf[a]) return pack_ray(OUT_SKY, 0, cix, longint'(DIST_MAX), 1'b0, org, dir);
      cix[a] += (dir[a] > 0) ? 1 : -1;
      d = len[a];
      len[a] += unit[a];
      if (cix[a] == 0 || cix[a] >= GRID) return pack_ray(OUT_SKY, 0, cix, d, 1'b0, org, dir);
    end
    return pack_ray(OUT_SKY, 0, cix, d, 1'b0, org, dir);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_req(logic f, logic [4:0] vx, vy, vz, logic [7:0] vb,
                          logic [20:0] ox, oy, oz, logic [15:0] dx, dy, dz);
    int g;
    in_valid <= 1; in_func <= f;
    in_voxel_x <= vx; in_voxel_y <= vy; in_voxel_z <= vz; in_voxel_block <= vb;
    in_origin_x <= ox; in_origin_y <= oy; in_origin_z <= oz;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    do @(posedge clk); while (!in_ready);
    if (!f) grid_model[(vz*GRID + vy)*GRID + vx] = vb;
    else pending_hits.push_back(trace_ray(ox, oy, oz, dx, dy, dz));
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic cast(logic [20:0] ox, oy, oz, logic [15:0] dx, dy, dz);
    send_req(1'b1, 5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom),
             ox, oy, oz, dx, dy, dz);
  endtask

  task automatic put_block(logic [4:0] x, y, z, logic [7:0] b);
    send_req(1'b0, x, y, z, b, 21'($urandom), 21'($urandom), 21'($urandom),
             16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [20:0] rand_org();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return {5'($urandom_range(1, 31)), 16'($urandom)};
    if (r < 92) return {5'd0, 16'($urandom)};
    return 21'($urandom);
  endfunction

  task automatic random_req();
    if ($urandom_range(0, 99) < 40) begin
      if ($urandom_range(0, 3) == 0)
        put_block(5'($urandom), 5'($urandom), 5'($urandom), 8'($urandom));
      else
        put_block(5'($urandom_range(10, 21)), 5'($urandom_range(10, 21)),
                  5'($urandom_range(10, 21)),
                  $urandom_range(0, 4) == 0 ? 8'd0 : 8'($urandom));
    end else
      cast(rand_org(), rand_org(), rand_org(), rand_dir(), rand_dir(), rand_dir());
  endtask

  task automatic test_directed();
    put_block(5'd5, 5'd5, 5'd5, 8'hFF);
    put_block(5'd31, 5'd31, 5'd31, 8'h01);
    put_block(5'd0, 5'd0, 5'd0, 8'h80);
    put_block(5'd20, 5'd5, 5'd5, 8'h5A);
    cast({5'd5, 16'h8000}, {5'd5, 16'h8000}, {5'd1, 16'h8000}, 16'h0000, 16'h0000, 16'h7FFF);
    cast({5'd5, 16'h0000}, {5'd5, 16'h4000}, {5'd5, 16'hFFFF}, 16'h0000, 16'h0000, 16'h0000);
    cast({5'd9, 16'h1234}, {5'd9, 16'h0}, {5'd9, 16'h0}, 16'h0000, 16'h0000, 16'h0000);
    cast({5'd0, 16'h8000}, {5'd5, 16'h8000}, {5'd5, 16'h8000}, 16'h7FFF, 16'h0, 16'h0);
    cast(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 16'h8000, 16'h8000, 16'h8000);
    cast({5'd31, 16'h0}, {5'd31, 16'h0}, {5'd30, 16'h0}, 16'h0, 16'h0, 16'h7FFF);
    cast({5'd1, 16'h8000}, {5'd5, 16'h8000}, {5'd5, 16'h8000}, 16'h7FFF, 16'h0, 16'h0);
    cast({5'd30, 16'h8000}, {5'd5, 16'h8000}, {5'd5, 16'h8000}, 16'h8000, 16'h0, 16'h0);
    cast({5'd16, 16'h8000}, {5'd16, 16'h8000}, {5'd16, 16'h8000}, 16'h0001, 16'h0, 16'h0);
    cast({5'd16, 16'h8000}, {5'd16, 16'h8000}, {5'd16, 16'h8000}, 16'h4000, 16'h4000,
         16'h4000);
    cast({5'd16, 16'h0}, {5'd16, 16'h0}, {5'd16, 16'h0}, 16'hC000, 16'hC000, 16'hC000);
    cast({5'd3, 16'h0}, {5'd3, 16'h0}, {5'd3, 16'h0}, 16'h2000, 16'h2000, 16'h2000);
    cast({5'd7, 16'hFFFF}, {5'd5, 16'h8000}, {5'd5, 16'h8000}, 16'hFFFF, 16'h0, 16'h0);
    put_block(5'd5, 5'd5, 5'd5, 8'h00);
    cast({5'd5, 16'h8000}, {5'd5, 16'h8000}, {5'd1, 16'h8000}, 16'h0000, 16'h0000, 16'h7FFF);
  endtask

  task automatic test_random(int count);
    repeat (count) random_req();
  endtask

  task automatic test_no_idle();
    no_gaps = 1;
    repeat (60) random_req();
    no_gaps = 0;
  endtask

  // receiver holds off long enough that the block backs up onto in_ready
  task automatic test_backpressure();
    hold_cnt = 3000;
    repeat (30) cast(rand_org(), rand_org(), rand_org(), rand_dir(), rand_dir(), rand_dir());
  endtask

  task automatic test_drain_pause();
    repeat (20) random_req();
    in_valid <= 0;
    wait (pending_hits.size() == 0);
    @(posedge clk);
    repeat (20) random_req();
  endtask

  always @(posedge clk) begin
    ray_result_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_hits.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          e = pending_hits.pop_front();
          if (out_outcome !== e.outcome) begin
            $error("outcome exp %0d got %0d", e.outcome, out_outcome); errors++;
          end
          if (out_hit_block !== e.hit_block) begin
            $error("hit_block exp %0d got %0d", e.hit_block, out_hit_block); errors++;
          end
          if (out_cell_x !== e.cell_x) begin
            $error("cell_x exp %0d got %0d", e.cell_x, out_cell_x); errors++;
          end
          if (out_cell_y !== e.cell_y) begin
            $error("cell_y exp %0d got %0d", e.cell_y, out_cell_y); errors++;
          end
          if (out_cell_z !== e.cell_z) begin
            $error("cell_z exp %0d got %0d", e.cell_z, out_cell_z); errors++;
          end
          if (out_distance !== e.distance) begin
            $error("distance exp %h got %h", e.distance, out_distance); errors++;
          end
          if (out_surface_x !== e.surface_x) begin
            $error("surface_x exp %h got %h", e.surface_x, out_surface_x); errors++;
          end
          if (out_surface_y !== e.surface_y) begin
            $error("surface_y exp %h got %h", e.surface_y, out_surface_y); errors++;
          end
          if (out_surface_z !== e.surface_z) begin
            $error("surface_z exp %h got %h", e.surface_z, out_surface_z); errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!no_gaps) stall_cnt = pick_gap();
      end
    end
  end

  initial begin
    for (int i = 0; i < GRID*GRID*GRID; i++) grid_model[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    test_directed();
    test_no_idle();
    test_backpressure();
    test_random(800);
    test_drain_pause();
    test_random(800);
    in_valid <= 0;
    wait (pending_hits.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_hits.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
